[rtl/mpr_pkg.sv]
// shared types and constants for the mesh packet receive parser
package mpr_pkg;

   localparam int MAX_PATH_DEFAULT    = 64;
   localparam int MAX_PAYLOAD_DEFAULT = 256;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_NODE_HASH       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TRANSPORT_MASK  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FLOOD_MASK      = 2'd2;

   localparam logic [7:0] NODE_HASH_RESET      = 8'd0;
   localparam logic [3:0] TRANSPORT_MASK_RESET = 4'd9;
   localparam logic [3:0] FLOOD_MASK_RESET     = 4'd3;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_SHORT    = 3'd1;
   localparam logic [2:0] ST_HDRCUT   = 3'd2;
   localparam logic [2:0] ST_PATHLONG = 3'd3;
   localparam logic [2:0] ST_PATHCUT  = 3'd4;
   localparam logic [2:0] ST_PAYLONG  = 3'd5;

   typedef enum logic [5:0] {
      PH_HEADER    = 6'b000001,
      PH_TRANSPORT = 6'b000010,
      PH_PATHLEN   = 6'b000100,
      PH_PATH      = 6'b001000,
      PH_PAYLOAD   = 6'b010000,
      PH_DISCARD   = 6'b100000
   } phase_type;

   typedef struct packed {
      logic [7:0] node_hash;
      logic [3:0] transport_mask;
      logic [3:0] flood_mask;
   } cfg_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [1:0]  route_mode;
      logic [3:0]  body_kind;
      logic [1:0]  version;
      logic [15:0] code_a;
      logic [15:0] code_b;
      logic [7:0]  hop_count;
      logic [8:0]  body_count;
      logic [7:0]  dedup_hash;
      logic        forward;
   } result_type;

endpackage

[rtl/mesh_packet_rx_parser.sv]
// top level of the mesh packet receive parser
// a frame's result is registered in the result register, or in the skid stage
// while a response waits; throughput: one byte request per cycle while the skid
// stage is empty; the per-byte phase step and hash update sit between the parser state
// registers, and the result register plus skid stage keep bytes flowing while a response waits
// reset: synchronous, active high; parser returns to header phase, csrs to defaults
module mesh_packet_rx_parser
   import mpr_pkg::*;
#(
   parameter int MAX_PATH    = MAX_PATH_DEFAULT,
   parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_byte_value,
   input  logic                  req_last_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [2:0]            rsp_status,
   output logic [1:0]            rsp_route_mode,
   output logic [3:0]            rsp_body_kind,
   output logic [1:0]            rsp_version,
   output logic [15:0]           rsp_transport_code_a,
   output logic [15:0]           rsp_transport_code_b,
   output logic [7:0]            rsp_hop_count,
   output logic [8:0]            rsp_body_count,
   output logic [7:0]            rsp_dedup_hash,
   output logic                  rsp_forward
);

   cfg_type    cfg_ff;
   logic       in_fire;
   logic       res_valid;
   result_type res;
   result_type rsp_data;
   logic       skid_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.node_hash      <= NODE_HASH_RESET;
         cfg_ff.transport_mask <= TRANSPORT_MASK_RESET;
         cfg_ff.flood_mask     <= FLOOD_MASK_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_NODE_HASH:      cfg_ff.node_hash      <= csr_data;
            CSR_TRANSPORT_MASK: cfg_ff.transport_mask <= csr_data[3:0];
            CSR_FLOOD_MASK:     cfg_ff.flood_mask     <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   assign req_stall = skid_full;
   assign in_fire   = req_valid && !req_stall;

   mpr_frame #(
      .MAX_PATH    (MAX_PATH),
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_frame (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_fire   (in_fire),
      .in_byte   (req_byte_value),
      .in_last   (req_last_byte),
      .res_valid (res_valid),
      .res       (res)
   );

   mpr_out u_out (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res       (res),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .skid_full (skid_full)
   );

   assign rsp_status           = rsp_data.status;
   assign rsp_route_mode       = rsp_data.route_mode;
   assign rsp_body_kind        = rsp_data.body_kind;
   assign rsp_version          = rsp_data.version;
   assign rsp_transport_code_a = rsp_data.code_a;
   assign rsp_transport_code_b = rsp_data.code_b;
   assign rsp_hop_count        = rsp_data.hop_count;
   assign rsp_body_count       = rsp_data.body_count;
   assign rsp_dedup_hash       = rsp_data.dedup_hash;
   assign rsp_forward          = rsp_data.forward;

endmodule

[rtl/mpr_frame.sv]
// per-byte frame parser state and result assembly
module mpr_frame
   import mpr_pkg::*;
#(
   parameter int MAX_PATH    = MAX_PATH_DEFAULT,
   parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       in_fire,
   input  logic [7:0] in_byte,
   input  logic       in_last,
   output logic       res_valid,
   output result_type res
);

   localparam int CW = $clog2(MAX_PAYLOAD + 2);

   phase_type      phase_ff, phase_in, phase_nx;
   logic [7:0]     field_count_ff, field_count_in;
   logic [7:0]     header_ff, header_in;
   logic [7:0]     hop_count_ff, hop_count_in;
   logic [15:0]    code_a_ff, code_a_in;
   logic [15:0]    code_b_ff, code_b_in;
   logic [7:0]     hash_ff, hash_in;
   logic [CW-1:0]  payload_count_ff, payload_count_in;
   logic           own_seen_ff, own_seen_in;
   logic [2:0]     sticky_ff, sticky_in;
   logic [2:0]     status;
   logic [7:0]     mix;

   always_comb begin
      phase_nx         = phase_ff;
      field_count_in   = field_count_ff;
      header_in        = header_ff;
      hop_count_in     = hop_count_ff;
      code_a_in        = code_a_ff;
      code_b_in        = code_b_ff;
      hash_in          = hash_ff;
      payload_count_in = payload_count_ff;
      own_seen_in      = own_seen_ff;
      sticky_in        = sticky_ff;
      status           = ST_OK;
      mix              = hash_ff ^ in_byte;
      unique case (phase_ff)
         PH_TRANSPORT: begin
            case (field_count_ff[1:0])
               2'd0:    code_a_in[7:0]  = in_byte;
               2'd1:    code_a_in[15:8] = in_byte;
               2'd2:    code_b_in[7:0]  = in_byte;
               default: code_b_in[15:8] = in_byte;
            endcase
            field_count_in = field_count_ff + 8'd1;
            if (field_count_ff[1:0] == 2'd3) begin
               phase_nx = PH_PATHLEN;
            end
            status = ST_HDRCUT;
         end
         PH_PATHLEN: begin
            hop_count_in   = in_byte;
            field_count_in = 8'd0;
            if (in_byte > 8'(MAX_PATH)) begin
               sticky_in = ST_PATHLONG;
               phase_nx  = PH_DISCARD;
               status    = ST_PATHLONG;
            end else if (in_byte == 8'd0) begin
               phase_nx = PH_PAYLOAD;
               status   = ST_OK;
            end else begin
               phase_nx = PH_PATH;
               status   = ST_PATHCUT;
            end
         end
         PH_PATH: begin
            if (in_byte == cfg.node_hash) begin
               own_seen_in = 1'b1;
            end
            field_count_in = field_count_ff + 8'd1;
            if (({1'b0, field_count_ff} + 9'd1) >= {1'b0, hop_count_ff}) begin
               phase_nx = PH_PAYLOAD;
               status   = ST_OK;
            end else begin
               status = ST_PATHCUT;
            end
         end
         PH_PAYLOAD: begin
            if (payload_count_ff < CW'(MAX_PAYLOAD)) begin
               hash_in          = {mix[6:0], mix[7]};
               payload_count_in = payload_count_ff + CW'(1);
               status           = sticky_ff;
            end else begin
               payload_count_in = CW'(MAX_PAYLOAD + 1);
               sticky_in        = ST_PAYLONG;
               status           = ST_PAYLONG;
            end
         end
         PH_DISCARD: begin
            status = sticky_ff;
         end
         default: begin
            header_in        = in_byte;
            field_count_in   = 8'd0;
            hop_count_in     = 8'd0;
            code_a_in        = 16'd0;
            code_b_in        = 16'd0;
            hash_in          = {4'd0, in_byte[5:2]};
            payload_count_in = '0;
            own_seen_in      = 1'b0;
            sticky_in        = ST_OK;
            phase_nx         = cfg.transport_mask[in_byte[1:0]] ? PH_TRANSPORT : PH_PATHLEN;
            status           = ST_SHORT;
         end
      endcase
      phase_in = in_last ? PH_HEADER : phase_nx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_HEADER;
         field_count_ff   <= 8'd0;
         header_ff        <= 8'd0;
         hop_count_ff     <= 8'd0;
         code_a_ff        <= 16'd0;
         code_b_ff        <= 16'd0;
         hash_ff          <= 8'd0;
         payload_count_ff <= '0;
         own_seen_ff      <= 1'b0;
         sticky_ff        <= ST_OK;
      end else if (in_fire) begin
         phase_ff         <= phase_in;
         field_count_ff   <= field_count_in;
         header_ff        <= header_in;
         hop_count_ff     <= hop_count_in;
         code_a_ff        <= code_a_in;
         code_b_ff        <= code_b_in;
         hash_ff          <= hash_in;
         payload_count_ff <= payload_count_in;
         own_seen_ff      <= own_seen_in;
         sticky_ff        <= sticky_in;
      end
   end

   assign res_valid       = in_fire && in_last;
   assign res.status      = status;
   assign res.route_mode  = header_in[1:0];
   assign res.body_kind   = header_in[5:2];
   assign res.version     = header_in[7:6];
   assign res.code_a      = code_a_in;
   assign res.code_b      = code_b_in;
   assign res.hop_count   = hop_count_in;
   assign res.body_count  = 9'(payload_count_in);
   assign res.dedup_hash  = hash_in;
   assign res.forward     = (status == ST_OK) && cfg.flood_mask[header_in[1:0]] && !own_seen_in;

endmodule

[rtl/mpr_out.sv]
// result register with skid stage towards the response channel
module mpr_out
   import mpr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       res_valid,
   input  result_type res,
   input  logic       rsp_stall,
   output logic       rsp_valid,
   output result_type rsp_data,
   output logic       skid_full
);

   logic       out_valid_ff;
   logic       skid_valid_ff;
   result_type out_ff;
   result_type skid_ff;
   logic       out_take;

   assign out_take = !out_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff && out_take) begin
         out_valid_ff  <= 1'b1;
         skid_valid_ff <= 1'b0;
      end else if (res_valid) begin
         if (out_take) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (out_take) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff && out_take) begin
         out_ff <= skid_ff;
      end else if (res_valid) begin
         if (out_take) begin
            out_ff <= res;
         end else begin
            skid_ff <= res;
         end
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;
   assign skid_full = skid_valid_ff;

endmodule
